// ===== hdl/kpc_pkg.sv =====
package kpc_pkg;

	localparam int NUM_KEYS  = 2;
	localparam int TICK_W    = 8;
	localparam int COUNT_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 8;

	localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [TICK_W-1:0]  DEBOUNCE_RST = TICK_W'(5);
	localparam logic [TICK_W-1:0]  LONG_RST     = TICK_W'(200);
	localparam logic [TICK_W-1:0]  GAP_RST      = TICK_W'(100);
	localparam logic [COUNT_W-1:0] MULTI_RST    = COUNT_W'(5);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE = 3'd0,
		CFG_LONG     = 3'd1,
		CFG_GAP      = 3'd2,
		CFG_MULTI    = 3'd3
	} kpc_cfg_idx_t;

	typedef struct packed {
		logic [TICK_W-1:0]  debounce_ticks;
		logic [TICK_W-1:0]  long_ticks;
		logic [TICK_W-1:0]  gap_ticks;
		logic [COUNT_W-1:0] multi_count;
	} kpc_cfg_t;

	typedef struct packed {
		logic short_ev;
		logic long_ev;
		logic multi_ev;
	} kpc_evt_t;

endpackage

// ===== hdl/kpc_lane.sv =====
module kpc_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              key_up,
	input  kpc_pkg::kpc_cfg_t cfg,
	output kpc_pkg::kpc_evt_t evt
);

	logic [kpc_pkg::TICK_W-1:0]  hold_q, hold_d;
	logic [kpc_pkg::TICK_W-1:0]  gap_q, gap_d;
	logic [kpc_pkg::COUNT_W-1:0] count_q, count_d;
	logic                        lock_q, lock_d;
	logic                        armed_q, armed_d;

	always_comb begin
		logic [kpc_pkg::TICK_W-1:0]  gap_inc;
		logic [kpc_pkg::TICK_W-1:0]  hold_inc;
		logic [kpc_pkg::COUNT_W-1:0] cnt_next;

		gap_inc  = (gap_q < kpc_pkg::TICK_MAX) ? gap_q + 1'b1 : gap_q;
		hold_inc = (hold_q < kpc_pkg::TICK_MAX) ? hold_q + 1'b1 : hold_q;
		if (gap_inc < cfg.gap_ticks) begin
			cnt_next = (count_q < kpc_pkg::COUNT_MAX) ? count_q + 1'b1 : count_q;
		end else begin
			cnt_next = kpc_pkg::COUNT_W'(1);
		end

		hold_d  = hold_q;
		gap_d   = gap_inc;
		count_d = count_q;
		lock_d  = lock_q;
		armed_d = armed_q;
		evt     = '0;

		if (key_up) begin
			lock_d = 1'b0;
			hold_d = '0;
			if (armed_q) begin
				if (cnt_next >= cfg.multi_count) begin
					count_d      = '0;
					evt.multi_ev = 1'b1;
				end else begin
					count_d = cnt_next;
				end
				armed_d      = 1'b0;
				evt.short_ev = 1'b1;
				gap_d        = '0;
			end
		end else if (!lock_q) begin
			hold_d = hold_inc;
			if (hold_inc > cfg.debounce_ticks) begin
				armed_d = 1'b1;
			end
			if (hold_inc > cfg.long_ticks) begin
				evt.long_ev = 1'b1;
				armed_d     = 1'b0;
				lock_d      = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= '0;
			gap_q   <= '0;
			count_q <= '0;
			lock_q  <= 1'b0;
			armed_q <= 1'b0;
		end else if (step) begin
			hold_q  <= hold_d;
			gap_q   <= gap_d;
			count_q <= count_d;
			lock_q  <= lock_d;
			armed_q <= armed_d;
		end
	end

	a_lock_not_armed: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q |-> !armed_q)
		else $error("locked key still holds an armed short press");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && key_up) |=> (hold_q == '0) && !lock_q && !armed_q)
		else $error("release did not clear hold state");

	a_short_clears_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(step && evt.short_ev) |=> (gap_q == '0))
		else $error("short press did not restart the gap timer");

endmodule

// ===== hdl/kpc_merge.sv =====
module kpc_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  kpc_pkg::kpc_evt_t             lane_evt [kpc_pkg::NUM_KEYS],
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [kpc_pkg::NUM_KEYS-1:0]  short_event,
	output logic [kpc_pkg::NUM_KEYS-1:0]  long_event,
	output logic [kpc_pkg::NUM_KEYS-1:0]  multi_event
);

	logic                         valid_q;
	logic [kpc_pkg::NUM_KEYS-1:0] short_q;
	logic [kpc_pkg::NUM_KEYS-1:0] long_q;
	logic [kpc_pkg::NUM_KEYS-1:0] multi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int k = 0; k < kpc_pkg::NUM_KEYS; k++) begin
				short_q[k] <= lane_evt[k].short_ev;
				long_q[k]  <= lane_evt[k].long_ev;
				multi_q[k] <= lane_evt[k].multi_ev;
			end
		end
	end

	assign busy        = valid_q & out_stall;
	assign out_valid   = valid_q;
	assign short_event = short_q;
	assign long_event  = long_q;
	assign multi_event = multi_q;

	a_take_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_q)
		else $error("accepted tick produced no result");

	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !take)
		else $error("tick accepted over a waiting result");

	a_multi_has_short: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ((multi_q & ~short_q) == '0))
		else $error("multi-press without a short press");

	a_short_long_apart: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ((short_q & long_q) == '0))
		else $error("short and long press on one key in one tick");

endmodule

// ===== hdl/key_press_classifier.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    key_released
// out       output     out_valid / out_stall  short_event, long_event, multi_event
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each key has its own lane that updates its timers in the cycle a tick is accepted.
// One tick per cycle is taken while in_stall is low; the result appears in the output register in the next cycle.
// The output register holds one result, so a tick is refused only while it is full and stalled.
// Reset loads the register defaults and clears all key state; cfg_ready is always high.
module key_press_classifier (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [kpc_pkg::NUM_KEYS-1:0]         key_released,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [kpc_pkg::NUM_KEYS-1:0]         short_event,
	output logic [kpc_pkg::NUM_KEYS-1:0]         long_event,
	output logic [kpc_pkg::NUM_KEYS-1:0]         multi_event,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [kpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [kpc_pkg::CFG_DAT_W-1:0]        cfg_data
);

	kpc_pkg::kpc_cfg_t cfg_q;
	kpc_pkg::kpc_evt_t lane_evt [kpc_pkg::NUM_KEYS];
	logic              take;
	logic              busy;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign take      = in_valid & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= kpc_pkg::DEBOUNCE_RST;
			cfg_q.long_ticks     <= kpc_pkg::LONG_RST;
			cfg_q.gap_ticks      <= kpc_pkg::GAP_RST;
			cfg_q.multi_count    <= kpc_pkg::MULTI_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kpc_pkg::CFG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_data;
				kpc_pkg::CFG_LONG:     cfg_q.long_ticks     <= cfg_data;
				kpc_pkg::CFG_GAP:      cfg_q.gap_ticks      <= cfg_data;
				kpc_pkg::CFG_MULTI:    cfg_q.multi_count    <= cfg_data[kpc_pkg::COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	for (genvar k = 0; k < kpc_pkg::NUM_KEYS; k++) begin : g_lane
		kpc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (take),
			.key_up (key_released[k]),
			.cfg    (cfg_q),
			.evt    (lane_evt[k])
		);
	end

	kpc_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.lane_evt    (lane_evt),
		.busy        (busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.short_event (short_event),
		.long_event  (long_event),
		.multi_event (multi_event)
	);

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output can move");

	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted tick did not reach the output");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(short_event)
			&& $stable(long_event) && $stable(multi_event))
		else $error("stalled result changed");

endmodule

// ===== test/key_press_classifier_test.sv =====
module key_press_classifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [kpc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

	typedef struct packed {
		logic [kpc_pkg::NUM_KEYS-1:0] short_ev;
		logic [kpc_pkg::NUM_KEYS-1:0] long_ev;
		logic [kpc_pkg::NUM_KEYS-1:0] multi_ev;
	} tick_events_t;

	class key_event_board;
		logic [kpc_pkg::TICK_W-1:0]  debounce;
		logic [kpc_pkg::TICK_W-1:0]  long_limit;
		logic [kpc_pkg::TICK_W-1:0]  gap_limit;
		logic [kpc_pkg::COUNT_W-1:0] multi_target;
		logic [kpc_pkg::TICK_W-1:0]  hold[kpc_pkg::NUM_KEYS];
		logic [kpc_pkg::TICK_W-1:0]  gap_age[kpc_pkg::NUM_KEYS];
		logic [kpc_pkg::COUNT_W-1:0] presses[kpc_pkg::NUM_KEYS];
		bit                          locked[kpc_pkg::NUM_KEYS];
		bit                          armed[kpc_pkg::NUM_KEYS];
		tick_events_t                expected_events[$];
		int                          errors;
		int                          ticks_seen;

		function new();
			debounce = kpc_pkg::DEBOUNCE_RST;
			long_limit = kpc_pkg::LONG_RST;
			gap_limit = kpc_pkg::GAP_RST;
			multi_target = kpc_pkg::MULTI_RST;
			errors = 0;
			ticks_seen = 0;
			for (int k = 0; k < kpc_pkg::NUM_KEYS; k++) begin
				hold[k] = '0;
				gap_age[k] = '0;
				presses[k] = '0;
				locked[k] = 1'b0;
				armed[k] = 1'b0;
			end
		endfunction

		function void set_reg(logic [kpc_pkg::CFG_IDX_W-1:0] idx,
			logic [kpc_pkg::CFG_DAT_W-1:0] data);
			case (idx)
				kpc_pkg::CFG_DEBOUNCE: debounce = data;
				kpc_pkg::CFG_LONG: long_limit = data;
				kpc_pkg::CFG_GAP: gap_limit = data;
				kpc_pkg::CFG_MULTI: multi_target = data[kpc_pkg::COUNT_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_tick(logic [kpc_pkg::NUM_KEYS-1:0] released);
			tick_events_t ev;
			ev = '0;
			for (int k = 0; k < kpc_pkg::NUM_KEYS; k++) begin
				if (gap_age[k] != kpc_pkg::TICK_MAX)
					gap_age[k]++;
				if (released[k]) begin
					locked[k] = 1'b0;
					hold[k] = '0;
					if (armed[k]) begin
						if (gap_age[k] < gap_limit) begin
							if (presses[k] != kpc_pkg::COUNT_MAX)
								presses[k]++;
						end else begin
							presses[k] = kpc_pkg::COUNT_W'(1);
						end
						if (presses[k] >= multi_target) begin
							presses[k] = '0;
							ev.multi_ev[k] = 1'b1;
						end
						armed[k] = 1'b0;
						ev.short_ev[k] = 1'b1;
						gap_age[k] = '0;
					end
				end else if (!locked[k]) begin
					if (hold[k] != kpc_pkg::TICK_MAX)
						hold[k]++;
					if (hold[k] > debounce)
						armed[k] = 1'b1;
					if (hold[k] > long_limit) begin
						ev.long_ev[k] = 1'b1;
						armed[k] = 1'b0;
						locked[k] = 1'b1;
					end
				end
			end
			expected_events.push_back(ev);
		endfunction

		function int pending();
			return expected_events.size();
		endfunction

		task report(string msg);
			errors++;
			$display("%0t mismatch: %s", $realtime, msg);
		endtask

		task check_events(tick_events_t got);
			tick_events_t want;
			if (expected_events.size() == 0) begin
				report($sformatf("unexpected result %b/%b/%b", got.short_ev, got.long_ev,
					got.multi_ev));
			end else begin
				want = expected_events.pop_front();
				if (got.short_ev !== want.short_ev)
					report($sformatf("tick %0d short_event %b, expected %b", ticks_seen,
						got.short_ev, want.short_ev));
				if (got.long_ev !== want.long_ev)
					report($sformatf("tick %0d long_event %b, expected %b", ticks_seen,
						got.long_ev, want.long_ev));
				if (got.multi_ev !== want.multi_ev)
					report($sformatf("tick %0d multi_event %b, expected %b", ticks_seen,
						got.multi_ev, want.multi_ev));
			end
			ticks_seen++;
		endtask

		task finish_check();
			if (expected_events.size() != 0)
				report($sformatf("%0d results never arrived", expected_events.size()));
		endtask
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [kpc_pkg::NUM_KEYS-1:0]  key_released = '1;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [kpc_pkg::NUM_KEYS-1:0]  short_event;
	logic [kpc_pkg::NUM_KEYS-1:0]  long_event;
	logic [kpc_pkg::NUM_KEYS-1:0]  multi_event;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [kpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [kpc_pkg::CFG_DAT_W-1:0] cfg_data = '0;

	key_event_board board = new();
	bit calm = 1'b0;
	int cur_debounce = kpc_pkg::DEBOUNCE_RST;
	int cur_long = kpc_pkg::LONG_RST;
	int cur_gap = kpc_pkg::GAP_RST;
	bit key_down[kpc_pkg::NUM_KEYS];
	int ticks_left[kpc_pkg::NUM_KEYS];

	key_press_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.key_released(key_released),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.short_event(short_event),
		.long_event(long_event),
		.multi_event(multi_event),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (out_valid && !out_stall)
					board.check_events('{short_ev: short_event, long_ev: long_event,
						multi_ev: multi_event});
				out_stall <= !calm && ($urandom_range(0, 99) < 25);
			end
		end
	end

	task send_tick(logic [kpc_pkg::NUM_KEYS-1:0] released);
		while (!calm && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			key_released <= kpc_pkg::NUM_KEYS'($urandom_range(0,
				(1 << kpc_pkg::NUM_KEYS) - 1));
			@(posedge clk);
		end
		in_valid <= 1'b1;
		key_released <= released;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_tick(released);
	endtask

	task wait_idle();
		while (board.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task write_reg(logic [kpc_pkg::CFG_IDX_W-1:0] idx, logic [kpc_pkg::CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_reg(idx, data);
	endtask

	task load_settings(int deb, int lng, int gap, int multi, bit spare);
		wait_idle();
		write_reg(kpc_pkg::CFG_DEBOUNCE, kpc_pkg::CFG_DAT_W'(deb));
		write_reg(kpc_pkg::CFG_LONG, kpc_pkg::CFG_DAT_W'(lng));
		write_reg(kpc_pkg::CFG_GAP, kpc_pkg::CFG_DAT_W'(gap));
		write_reg(kpc_pkg::CFG_MULTI, kpc_pkg::CFG_DAT_W'(multi));
		if (spare)
			write_reg(CFG_SPARE, kpc_pkg::CFG_DAT_W'($urandom_range(0, 255)));
		cfg_valid <= 1'b0;
		cur_debounce = deb;
		cur_long = lng;
		cur_gap = gap;
	endtask

	function automatic int pick_hold();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return cur_debounce + 1 + $urandom_range(0, 1);
		else if (roll < 7)
			return $urandom_range(1, cur_debounce + 1);
		return cur_long + 1 + $urandom_range(0, 2);
	endfunction

	function automatic int pick_release();
		int span;
		span = (cur_gap > 1) ? cur_gap - 1 : 1;
		if (span > 30)
			span = 30;
		if ($urandom_range(0, 9) < 7 || cur_gap > 40)
			return $urandom_range(1, span);
		return cur_gap + $urandom_range(0, 3);
	endfunction

	function automatic logic [kpc_pkg::NUM_KEYS-1:0] next_tick();
		logic [kpc_pkg::NUM_KEYS-1:0] released;
		for (int k = 0; k < kpc_pkg::NUM_KEYS; k++) begin
			if (ticks_left[k] == 0) begin
				key_down[k] = !key_down[k];
				ticks_left[k] = key_down[k] ? pick_hold() : pick_release();
			end
			ticks_left[k]--;
			released[k] = !key_down[k];
		end
		if ($urandom_range(0, 99) < 8)
			released = kpc_pkg::NUM_KEYS'($urandom_range(0, (1 << kpc_pkg::NUM_KEYS) - 1));
		return released;
	endfunction

	task run_phase(int deb, int lng, int gap, int multi, int count, bit quiet, bit spare);
		load_settings(deb, lng, gap, multi, spare);
		calm = quiet;
		for (int k = 0; k < kpc_pkg::NUM_KEYS; k++) begin
			key_down[k] = 1'b0;
			ticks_left[k] = $urandom_range(0, 3);
		end
		repeat (count)
			send_tick(next_tick());
		in_valid <= 1'b0;
		calm = 1'b0;
	endtask

	initial begin
		logic [kpc_pkg::NUM_KEYS-1:0] default_script[$];
		logic [kpc_pkg::NUM_KEYS-1:0] small_script[$];
		int deb;
		int lng;

		default_script = '{2'b11, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b10, 2'b11};
		small_script = '{2'b00, 2'b11, 2'b00, 2'b11, 2'b00, 2'b00, 2'b00, 2'b00, 2'b01,
			2'b11, 2'b10, 2'b11};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The register defaults are checked before anything is written.
		foreach (default_script[i])
			send_tick(default_script[i]);
		in_valid <= 1'b0;

		load_settings(0, 2, 3, 2, 1'b0);
		foreach (small_script[i])
			send_tick(small_script[i]);
		in_valid <= 1'b0;

		run_phase(1, 6, 10, 2, 90, 1'b1, 1'b0);
		run_phase(0, 1, 1, 7, 50, 1'b0, 1'b0);
		run_phase(253, 254, 255, 7, 260, 1'b0, 1'b0);

		// A long limit of 255 lets the hold timer saturate without a long press.
		run_phase(2, 255, 0, 1, 160, 1'b0, 1'b1);
		run_phase(1, 5, 8, 0, 50, 1'b0, 1'b1);

		repeat (3) begin
			deb = $urandom_range(0, 6);
			lng = deb + $urandom_range(1, 10);
			run_phase(deb, lng, $urandom_range(1, 20), $urandom_range(2, 7), 25, 1'b0,
				1'b0);
		end

		wait_idle();
		repeat (5) @(posedge clk);
		board.finish_check();
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
